// File: rtl/core/dapqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapqm_pkg
// Shared constants and register codes of the two-axis PID quad mixer.
// ----------------------------------------------------------------------------
package dapqm_pkg;

	localparam int unsigned LONG_PRESS_MS = 2000;
	localparam int unsigned DEBOUNCE_MS   = 50;
	localparam int unsigned RETRY_LIMIT   = 3;
	localparam int unsigned PWM_LOW       = 1000;
	localparam int unsigned PWM_HIGH      = 2000;
	localparam int unsigned FRAC_BITS     = 20;
	localparam int unsigned MS_PER_S      = 1000;
	localparam int unsigned MS_PER_S_BITS = 10;

	typedef enum logic [2:0] {
		REG_TGT_PITCH = 3'd0,
		REG_TGT_ROLL  = 3'd1,
		REG_BASE_THR  = 3'd2,
		REG_THR_OVR   = 3'd3,
		REG_GAIN_P    = 3'd4,
		REG_GAIN_I    = 3'd5,
		REG_GAIN_D    = 3'd6
	} cfg_idx_t;

endpackage

// File: rtl/core/dual_axis_pid_quad_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_axis_pid_quad_mixer_unit
// Two-axis attitude PID with an X-form quad mixer, bit-serial datapath.
// ----------------------------------------------------------------------------
// Each input transaction is one control tick; each tick yields exactly one
// output transaction with four motor pulses and the armed and fault flags.
// Both channels use valid/ready. Gains, setpoints and throttle are written
// through the APB-style port; the user must do so only while the block is
// idle, which the block itself does not enforce. Each good tick runs the
// shared bit-serial multiplier (one multiplier bit per cycle) and the shared
// restoring divider (one quotient bit per cycle, 64 bits) through seven
// operations per axis. A failed read or a faulted tick goes from S_DECODE
// straight to S_DONE. One tick is processed at a time; the result sits in an
// output register, so a new tick is taken while the previous result still waits.
// When the receiver stalls, a finished tick waits until the output register
// frees up. Reset disarms, clears the fault, the retry count, the timestamp,
// the integrators and last errors, and loads the default configuration.
// ----------------------------------------------------------------------------
module dual_axis_pid_quad_mixer_unit
	import dapqm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               sample_ok,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] roll_angle,
	input  logic [31:0]        time_ms,
	input  logic               button_release,
	input  logic [15:0]        press_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [10:0]        motor_front_a,
	output logic [10:0]        motor_front_b,
	output logic [10:0]        motor_rear_a,
	output logic [10:0]        motor_rear_b,
	output logic               armed_flag,
	output logic               fault_flag
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_EDT, S_INTEG, S_KP, S_KI, S_KIDIV,
		S_KD, S_K1000, S_KDDIV, S_MIX, S_DONE
	} state_t;

	localparam logic signed [63:0] MIX_LO = 64'(PWM_LOW) << FRAC_BITS;
	localparam logic signed [63:0] MIX_HI = 64'(PWM_HIGH) << FRAC_BITS;
	localparam logic signed [47:0] I_MAX  = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] I_MIN  = {1'b1, {47{1'b0}}};

	state_t state_q;

	logic signed [15:0] tgt_pitch_q, tgt_roll_q;
	logic [10:0]        base_thr_q;
	logic signed [11:0] thr_ovr_q;
	logic [15:0]        kp_q, ki_q, kd_q;

	logic               armed_q, faulted_q;
	logic [2:0]         retry_q;
	logic [31:0]        last_time_q;
	logic signed [47:0] integ_q [2];
	logic signed [16:0] last_err_q [2];

	logic               cap_ok_q, cap_rel_q;
	logic signed [15:0] cap_pitch_q, cap_roll_q;
	logic [31:0]        cap_time_q;
	logic [15:0]        cap_press_q;

	logic               axis_q;
	logic [31:0]        dt_q;
	logic signed [16:0] err_q [2];
	logic signed [47:0] acc_q;
	logic signed [17:0] diff_q;
	logic signed [63:0] sum_q;
	logic signed [63:0] pid_q [2];
	logic [10:0]        thr_q;
	logic [1:0]         mix_idx_q;
	logic [10:0]        motor_q [4];
	logic               flag_armed_q, flag_fault_q;

	logic signed [63:0] mcand_q, prod_q;
	logic [31:0]        mpl_q;
	logic [6:0]         cnt_q;
	logic [63:0]        num_q, quo_q;
	logic [31:0]        den_q, rem_q;
	logic               neg_q;

	logic               out_valid_q;
	logic [10:0]        out_motor_q [4];
	logic               out_armed_q, out_fault_q;

	logic               cfg_wr;
	logic               in_acc;
	logic               out_free;
	logic [31:0]        dt_raw, dt_w;
	logic signed [16:0] err_p_w, err_r_w;
	logic [10:0]        thr_w;
	logic               is_long, is_short, armed_n;
	logic [3:0]         retry_inc;
	logic               fault_n;
	logic signed [63:0] mul_add, mul_nx;
	logic [32:0]        rem_sh;
	logic               div_ge;
	logic [31:0]        rem_nx;
	logic [63:0]        quo_nx;
	logic signed [63:0] integ_sum;
	logic signed [47:0] integ_sat;
	logic signed [63:0] div_fin;
	logic [63:0]        prod_abs;
	logic signed [63:0] mix_val, mix_clamp;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (cfg_idx_t'(paddr[4:2]))
			REG_TGT_PITCH: prdata = {16'd0, tgt_pitch_q};
			REG_TGT_ROLL:  prdata = {16'd0, tgt_roll_q};
			REG_BASE_THR:  prdata = {21'd0, base_thr_q};
			REG_THR_OVR:   prdata = {20'd0, thr_ovr_q};
			REG_GAIN_P:    prdata = {16'd0, kp_q};
			REG_GAIN_I:    prdata = {16'd0, ki_q};
			REG_GAIN_D:    prdata = {16'd0, kd_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_comb begin
		dt_raw    = cap_time_q - last_time_q;
		dt_w      = (dt_raw == 32'd0) ? 32'd1 : dt_raw;
		err_p_w   = {tgt_pitch_q[15], tgt_pitch_q} - {cap_pitch_q[15], cap_pitch_q};
		err_r_w   = {tgt_roll_q[15], tgt_roll_q} - {cap_roll_q[15], cap_roll_q};
		thr_w     = thr_ovr_q[11] ? base_thr_q : thr_ovr_q[10:0];
		is_long   = cap_press_q >= 16'(LONG_PRESS_MS);
		is_short  = !is_long && (cap_press_q >= 16'(DEBOUNCE_MS));
		armed_n   = armed_q;
		if (cap_rel_q) begin
			if (is_long) begin
				armed_n = 1'b0;
			end else if (is_short) begin
				armed_n = !armed_q;
			end
		end
		retry_inc = {1'b0, retry_q} + 4'd1;
		fault_n   = retry_inc > 4'(RETRY_LIMIT);

		mul_add   = mpl_q[31] ? mcand_q : 64'sd0;
		mul_nx    = {prod_q[62:0], 1'b0} + mul_add;

		rem_sh    = {rem_q, num_q[63]};
		div_ge    = rem_sh >= {1'b0, den_q};
		rem_nx    = div_ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
		quo_nx    = {quo_q[62:0], div_ge};
		div_fin   = neg_q ? sum_q - $signed(quo_q) : sum_q + $signed(quo_q);
		prod_abs  = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);

		integ_sum = {{16{integ_q[axis_q][47]}}, integ_q[axis_q]} + prod_q;
		if (integ_sum[63:47] == {17{integ_sum[63]}}) begin
			integ_sat = integ_sum[47:0];
		end else begin
			integ_sat = integ_sum[63] ? I_MIN : I_MAX;
		end

		mix_val   = $signed({33'd0, thr_q, 20'd0})
			+ (mix_idx_q[1] ? -pid_q[0] : pid_q[0])
			+ (mix_idx_q[0] ? -pid_q[1] : pid_q[1]);
		if (mix_val < MIX_LO) begin
			mix_clamp = MIX_LO;
		end else if (mix_val > MIX_HI) begin
			mix_clamp = MIX_HI;
		end else begin
			mix_clamp = mix_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tgt_pitch_q  <= '0;
			tgt_roll_q   <= '0;
			base_thr_q   <= 11'd1200;
			thr_ovr_q    <= -12'sd1;
			kp_q         <= 16'd2867;
			ki_q         <= 16'd82;
			kd_q         <= 16'd41;
			armed_q      <= 1'b0;
			faulted_q    <= 1'b0;
			retry_q      <= '0;
			last_time_q  <= '0;
			integ_q[0]   <= '0;
			integ_q[1]   <= '0;
			last_err_q[0] <= '0;
			last_err_q[1] <= '0;
			cap_ok_q     <= 1'b0;
			cap_rel_q    <= 1'b0;
			cap_pitch_q  <= '0;
			cap_roll_q   <= '0;
			cap_time_q   <= '0;
			cap_press_q  <= '0;
			axis_q       <= 1'b0;
			dt_q         <= '0;
			err_q[0]     <= '0;
			err_q[1]     <= '0;
			acc_q        <= '0;
			diff_q       <= '0;
			sum_q        <= '0;
			pid_q[0]     <= '0;
			pid_q[1]     <= '0;
			thr_q        <= '0;
			mix_idx_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				motor_q[i]     <= '0;
				out_motor_q[i] <= '0;
			end
			flag_armed_q <= 1'b0;
			flag_fault_q <= 1'b0;
			mcand_q      <= '0;
			prod_q       <= '0;
			mpl_q        <= '0;
			cnt_q        <= '0;
			num_q        <= '0;
			quo_q        <= '0;
			den_q        <= '0;
			rem_q        <= '0;
			neg_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_armed_q  <= 1'b0;
			out_fault_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx_t'(paddr[4:2]))
					REG_TGT_PITCH: tgt_pitch_q <= pwdata[15:0];
					REG_TGT_ROLL:  tgt_roll_q  <= pwdata[15:0];
					REG_BASE_THR:  base_thr_q  <= pwdata[10:0];
					REG_THR_OVR:   thr_ovr_q   <= pwdata[11:0];
					REG_GAIN_P:    kp_q        <= pwdata[15:0];
					REG_GAIN_I:    ki_q        <= pwdata[15:0];
					REG_GAIN_D:    kd_q        <= pwdata[15:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cap_ok_q    <= sample_ok;
						cap_rel_q   <= button_release;
						cap_pitch_q <= pitch_angle;
						cap_roll_q  <= roll_angle;
						cap_time_q  <= time_ms;
						cap_press_q <= press_ms;
						state_q     <= S_DECODE;
					end
				end
				S_DECODE: begin
					for (int i = 0; i < 4; i++) begin
						motor_q[i] <= '0;
					end
					if (faulted_q) begin
						flag_armed_q <= 1'b0;
						flag_fault_q <= 1'b1;
						state_q      <= S_DONE;
					end else begin
						armed_q <= armed_n;
						if (cap_rel_q && is_long) begin
							integ_q[0]    <= '0;
							integ_q[1]    <= '0;
							last_err_q[0] <= '0;
							last_err_q[1] <= '0;
						end
						if (!cap_ok_q) begin
							faulted_q    <= fault_n;
							retry_q      <= retry_inc[3] ? 3'd7 : retry_inc[2:0];
							flag_armed_q <= armed_n && !fault_n;
							flag_fault_q <= fault_n;
							state_q      <= S_DONE;
						end else begin
							retry_q      <= '0;
							last_time_q  <= cap_time_q;
							dt_q         <= dt_w;
							err_q[0]     <= err_p_w;
							err_q[1]     <= err_r_w;
							thr_q        <= thr_w;
							flag_armed_q <= armed_n;
							flag_fault_q <= 1'b0;
							axis_q       <= 1'b0;
							mcand_q      <= 64'(err_p_w);
							mpl_q        <= dt_w;
							prod_q       <= '0;
							cnt_q        <= 7'd32;
							state_q      <= S_EDT;
						end
					end
				end
				S_EDT, S_KP, S_KI, S_KD, S_K1000: begin
					if (cnt_q != 7'd0) begin
						prod_q <= mul_nx;
						mpl_q  <= {mpl_q[30:0], 1'b0};
						cnt_q  <= cnt_q - 7'd1;
					end else begin
						unique case (state_q)
							S_EDT: begin
								state_q <= S_INTEG;
							end
							S_KP: begin
								sum_q   <= prod_q;
								mcand_q <= 64'(acc_q);
								mpl_q   <= {ki_q, 16'd0};
								prod_q  <= '0;
								cnt_q   <= 7'd16;
								state_q <= S_KI;
							end
							S_KI: begin
								neg_q   <= prod_q[63];
								num_q   <= prod_abs;
								den_q   <= 32'(MS_PER_S);
								rem_q   <= '0;
								quo_q   <= '0;
								cnt_q   <= 7'd64;
								state_q <= S_KIDIV;
							end
							S_KD: begin
								mcand_q <= prod_q;
								mpl_q   <= {MS_PER_S_BITS'(MS_PER_S),
									(32 - MS_PER_S_BITS)'(0)};
								prod_q  <= '0;
								cnt_q   <= 7'(MS_PER_S_BITS);
								state_q <= S_K1000;
							end
							default: begin
								neg_q   <= prod_q[63];
								num_q   <= prod_abs;
								den_q   <= dt_q;
								rem_q   <= '0;
								quo_q   <= '0;
								cnt_q   <= 7'd64;
								state_q <= S_KDDIV;
							end
						endcase
					end
				end
				S_INTEG: begin
					integ_q[axis_q]    <= integ_sat;
					acc_q              <= integ_sat;
					diff_q             <= {err_q[axis_q][16], err_q[axis_q]}
						- {last_err_q[axis_q][16], last_err_q[axis_q]};
					last_err_q[axis_q] <= err_q[axis_q];
					mcand_q            <= 64'(err_q[axis_q]);
					mpl_q              <= {kp_q, 16'd0};
					prod_q             <= '0;
					cnt_q              <= 7'd16;
					state_q            <= S_KP;
				end
				S_KIDIV, S_KDDIV: begin
					if (cnt_q != 7'd0) begin
						num_q <= {num_q[62:0], 1'b0};
						rem_q <= rem_nx;
						quo_q <= quo_nx;
						cnt_q <= cnt_q - 7'd1;
					end else if (state_q == S_KIDIV) begin
						sum_q   <= div_fin;
						mcand_q <= 64'(diff_q);
						mpl_q   <= {kd_q, 16'd0};
						prod_q  <= '0;
						cnt_q   <= 7'd16;
						state_q <= S_KD;
					end else begin
						pid_q[axis_q] <= div_fin;
						if (!axis_q) begin
							axis_q  <= 1'b1;
							mcand_q <= 64'(err_q[1]);
							mpl_q   <= dt_q;
							prod_q  <= '0;
							cnt_q   <= 7'd32;
							state_q <= S_EDT;
						end else begin
							mix_idx_q <= '0;
							state_q   <= S_MIX;
						end
					end
				end
				S_MIX: begin
					motor_q[mix_idx_q] <= armed_q ? mix_clamp[FRAC_BITS +: 11] : 11'd0;
					mix_idx_q          <= mix_idx_q + 2'd1;
					if (mix_idx_q == 2'd3) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						for (int i = 0; i < 4; i++) begin
							out_motor_q[i] <= motor_q[i];
						end
						out_armed_q <= flag_armed_q;
						out_fault_q <= flag_fault_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_front_a = out_motor_q[0];
	assign motor_front_b = out_motor_q[1];
	assign motor_rear_a  = out_motor_q[2];
	assign motor_rear_b  = out_motor_q[3];
	assign armed_flag    = out_armed_q;
	assign fault_flag    = out_fault_q;

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		faulted_q |=> faulted_q)
		else $error("Fault latch cleared without reset.");

	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_flag |-> !armed_flag && motor_front_a == 11'd0
			&& motor_rear_b == 11'd0)
		else $error("Faulted transaction drives motors or shows armed.");

	a_disarmed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !armed_flag |-> motor_front_a == 11'd0 && motor_front_b == 11'd0
			&& motor_rear_a == 11'd0 && motor_rear_b == 11'd0)
		else $error("Disarmed transaction drives motors.");

	a_motor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && armed_flag && motor_front_a != 11'd0 |->
			motor_front_a >= 11'(PWM_LOW) && motor_front_a <= 11'(PWM_HIGH))
		else $error("Motor pulse outside the clamp range.");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
		else $error("Finished tick not moved to the output register.");

endmodule
